// ----- hw/rtl/edts_pkg.sv -----
package edts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 48;
  localparam int REQ_W     = 2;

  localparam logic [TIME_W-1:0] DELAY_FLOOR = TIME_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_ARM    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_EXPIRY = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_t;

endpackage

// ----- hw/rtl/edts_if.sv -----
interface edts_req_if
  import edts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] now;

  modport source (output valid, req_type, slot, deadline, now, input ready);
  modport sink (input valid, req_type, slot, deadline, now, output ready);
endinterface

interface edts_rsp_if
  import edts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              fired_valid;
  logic [SLOT_W-1:0] fired_slot;
  logic              timer_armed;
  logic [TIME_W-1:0] next_delay;

  modport source (output valid, fired_valid, fired_slot, timer_armed, next_delay,
                  input ready);
  modport sink (input valid, fired_valid, fired_slot, timer_armed, next_delay,
                output ready);
endinterface

// ----- hw/rtl/edts_ram.sv -----
module edts_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/earliest_deadline_timer_slots_core.sv -----
// Earliest-deadline timer over sixteen slots. Each request (arm, cancel,
// timer expiry, or query for type three) gives exactly one response item
// carrying the fired slot, if any, and the delay to the earliest armed
// deadline (at least 1, or 0 with timer_armed low when nothing is armed).
// Deadlines sit in a single-port-write, registered-read RAM; armed marks are
// flops cleared by reset. From acceptance to the response item, a request
// sweeps the RAM one slot per cycle, lets the last read land, closes the
// sweep and forms the result. The sweep keeps the earliest and the second
// earliest armed deadline so an expiry needs a single sweep. A new request
// is taken no earlier than the cycle after the previous response has been
// accepted, so a request is never taken while another is in progress.
module earliest_deadline_timer_slots_core
  import edts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  edts_req_if.sink    req,
  edts_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t              state;
  logic [NUM_SLOTS-1:0] armed;
  req_type_t           cur_req;
  logic [TIME_W-1:0]   cur_now;

  logic [CNT_W-1:0]    cnt;
  logic                cmp_vld;
  logic [IDX_W-1:0]    cmp_idx;
  logic                cmp_arm;

  logic                best_vld;
  logic [IDX_W-1:0]    best_idx;
  logic [TIME_W-1:0]   best_dl;
  logic                sec_vld;
  logic [TIME_W-1:0]   sec_dl;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  logic [TIME_W-1:0]   ram_rdata;

  logic                accept;
  logic                slot_ok;
  logic                is_expiry;
  logic                sel_vld;
  logic [TIME_W-1:0]   sel_dl;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE) && !rsp.valid;
  assign slot_ok   = 32'(req.slot) < NUM_SLOTS;
  assign ram_we    = accept && (req_type_t'(req.req_type) == REQ_ARM) && slot_ok;
  assign ram_waddr = IDX_W'(req.slot);
  assign ram_raddr = cnt[IDX_W-1:0];
  assign is_expiry = (cur_req == REQ_EXPIRY);
  assign sel_vld   = is_expiry ? sec_vld : best_vld;
  assign sel_dl    = is_expiry ? sec_dl : best_dl;

  edts_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (TIME_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.deadline),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      armed     <= '0;
      cnt       <= '0;
      cmp_vld   <= 1'b0;
      best_vld  <= 1'b0;
      sec_vld   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_req  <= req_type_t'(req.req_type);
            cur_now  <= req.now;
            cnt      <= '0;
            cmp_vld  <= 1'b0;
            best_vld <= 1'b0;
            sec_vld  <= 1'b0;
            if (slot_ok) begin
              if (req_type_t'(req.req_type) == REQ_ARM) begin
                armed[IDX_W'(req.slot)] <= (req.deadline != '0);
              end else if (req_type_t'(req.req_type) == REQ_CANCEL) begin
                armed[IDX_W'(req.slot)] <= 1'b0;
              end
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt < CNT_W'(NUM_SLOTS)) begin
            cmp_idx <= cnt[IDX_W-1:0];
            cmp_arm <= armed[cnt[IDX_W-1:0]];
            cnt     <= cnt + CNT_W'(1);
            cmp_vld <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld && cmp_arm) begin
            if (!best_vld || ram_rdata < best_dl) begin
              best_vld <= 1'b1;
              best_idx <= cmp_idx;
              best_dl  <= ram_rdata;
              sec_vld  <= best_vld;
              sec_dl   <= best_dl;
            end else if (!sec_vld || ram_rdata < sec_dl) begin
              sec_vld <= 1'b1;
              sec_dl  <= ram_rdata;
            end
          end
          if (cnt == CNT_W'(NUM_SLOTS) && !cmp_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (is_expiry && best_vld) begin
            armed[best_idx] <= 1'b0;
          end
          rsp.fired_valid <= is_expiry && best_vld;
          rsp.fired_slot  <= (is_expiry && best_vld) ? SLOT_W'(best_idx) : '0;
          rsp.timer_armed <= sel_vld;
          if (!sel_vld) begin
            rsp.next_delay <= '0;
          end else if (sel_dl > cur_now) begin
            rsp.next_delay <= sel_dl - cur_now;
          end else begin
            rsp.next_delay <= DELAY_FLOOR;
          end
          rsp.valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && !rsp.valid)
    else $error("item accepted while a response is pending");

  a_fired_slot_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) && rsp.fired_valid |-> !armed[IDX_W'(rsp.fired_slot)])
    else $error("fired slot still armed");

  a_idle_delay_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.timer_armed |-> rsp.next_delay == '0)
    else $error("nonzero delay with no slot armed");

  a_armed_delay_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.timer_armed |-> rsp.next_delay != '0)
    else $error("zero delay with a slot armed");
`endif

endmodule
